// ===== rtl/core/pulse_flow_meter_with_moving_average_core_defines.svh =====
`ifndef PULSE_FLOW_METER_WITH_MOVING_AVERAGE_CORE_DEFINES_SVH
`define PULSE_FLOW_METER_WITH_MOVING_AVERAGE_CORE_DEFINES_SVH

// property that must hold at every clock out of reset
`define PFM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked in the next cycle
`define PFM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/pfm_pkg.sv =====
`default_nettype none

package pfm_pkg;

    localparam int WINDOW_DEPTH_DEF = 30;
    localparam int QUEUE_DEPTH      = 4;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;
    localparam logic [CFG_IDX_W-1:0] REG_UPDATE_PERIOD = 1'b0;

    localparam logic [15:0] PERIOD_RESET = 16'd100;
    localparam logic [23:0] FACTOR_RESET = 24'd512;

    localparam int DIV_N_W = 64;
    localparam int DIV_D_W = 40;

    // 1000 ul/ml scaled by the Q8 factor, and again by 1000 ms/s
    localparam logic [17:0] VOL_SCALE  = 18'd256000;
    localparam logic [27:0] RATE_SCALE = 28'd256000000;

    typedef enum logic [1:0] {
        FUNC_PULSE = 2'd0,
        FUNC_TICK  = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_CALIB = 2'd3
    } pfm_func_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [23:0] actual_volume_ul;
    } pfm_in_t;

    typedef struct packed {
        logic [31:0] rate_ul_per_s;
        logic [31:0] total_volume_ul;
        logic [31:0] avg_rate_ul_per_s;
        logic [23:0] factor_q8;
    } pfm_out_t;

    typedef struct packed {
        pfm_func_t   op;
        logic [23:0] volume;
    } pfm_cmd_t;

    typedef struct packed {
        logic               start;
        logic [DIV_N_W-1:0] dividend;
        logic [DIV_D_W-1:0] divisor;
    } pfm_div_req_t;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [DIV_N_W-1:0] quotient;
    } pfm_div_rsp_t;

    function automatic logic [31:0] sat32(input logic [DIV_N_W-1:0] v);
        sat32 = (|v[DIV_N_W-1:32]) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic logic [23:0] sat24(input logic [DIV_N_W-1:0] v);
        sat24 = (|v[DIV_N_W-1:24]) ? 24'hFF_FFFF : v[23:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/pfm_ram.sv =====
`default_nettype none

module pfm_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 32,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pfm_div.sv =====
`default_nettype none

module pfm_div
    import pfm_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire pfm_div_req_t req,
    output pfm_div_rsp_t      rsp
);

    localparam int CNT_W = $clog2(DIV_N_W + 1);

    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               done_reg, done_next;
    logic [DIV_N_W-1:0] quo_reg, quo_next;
    logic [DIV_D_W-1:0] rem_reg, rem_next;
    logic [DIV_D_W-1:0] dvs_reg, dvs_next;

    logic [DIV_D_W:0]   shifted;
    logic [DIV_D_W:0]   diff;
    logic               ge;

    // restoring, one quotient bit per cycle, MSB first
    assign shifted = {rem_reg, quo_reg[DIV_N_W-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb
    begin
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (req.start)
        begin
            cnt_next = CNT_W'(DIV_N_W);
            quo_next = req.dividend;
            rem_next = '0;
            dvs_next = req.divisor;
        end
        else if (cnt_reg != '0)
        begin
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == CNT_W'(1));
            quo_next  = {quo_reg[DIV_N_W-2:0], ge};
            rem_next  = ge ? diff[DIV_D_W-1:0] : shifted[DIV_D_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = (cnt_reg != '0);
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

// ===== rtl/core/pfm_front.sv =====
`default_nettype none

`include "pulse_flow_meter_with_moving_average_core_defines.svh"

module pfm_front
    import pfm_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    item_valid,
    output logic         item_ready,
    input  wire pfm_in_t item,
    output logic         cmd_valid,
    input  wire logic    cmd_ready,
    output pfm_cmd_t     cmd
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    pfm_cmd_t         q_mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    pfm_cmd_t entry;
    logic     accept;
    logic     drop;
    logic     push;
    logic     pop;

    // calibrate with zero volume is a no-op; never queued
    assign entry.op     = pfm_func_t'(item.func);
    assign entry.volume = item.actual_volume_ul;
    assign drop         = (entry.op == FUNC_CALIB) && (item.actual_volume_ul == '0);

    assign item_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign accept     = item_valid && item_ready;
    assign push       = accept && !drop;
    assign cmd_valid  = (count_reg != '0);
    assign pop        = cmd_valid && cmd_ready;
    assign cmd        = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem_reg[wr_ptr_reg] <= entry;
        end
    end

    `PFM_ASSERT(a_count_bound, count_reg <= CNT_W'(QUEUE_DEPTH), "queue overfilled")
    `PFM_ASSERT_NEXT(a_push_grows, push && !pop, count_reg == $past(count_reg) + 1'b1, "push lost")
    `PFM_ASSERT_NEXT(a_drop_holds, accept && drop && !pop, $stable(count_reg), "dropped item queued")

endmodule

`default_nettype wire

// ===== rtl/core/pfm_back.sv =====
`default_nettype none

`include "pulse_flow_meter_with_moving_average_core_defines.svh"

module pfm_back
    import pfm_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic [15:0] period,
    input  wire logic        cmd_valid,
    output logic             cmd_ready,
    input  wire pfm_cmd_t    cmd,
    output logic             result_valid,
    input  wire logic        result_ready,
    output pfm_out_t         result
);

    localparam int WPOS_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W  = 32 + FILL_W;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_VOL  = 8'b0000_0100,
        S_RATE = 8'b0000_1000,
        S_PUSH = 8'b0001_0000,
        S_AVG  = 8'b0010_0000,
        S_OUT  = 8'b0100_0000,
        S_CAL  = 8'b1000_0000
    } pfm_state_t;

    pfm_state_t state_reg, state_next;

    logic [31:0] pulse_total_reg, pulse_total_next;
    logic [31:0] pulses_last_reg, pulses_last_next;
    logic [15:0] ticks_reg, ticks_next;
    logic [31:0] volume_sum_reg, volume_sum_next;
    logic [31:0] latest_rate_reg, latest_rate_next;
    logic [23:0] factor_reg, factor_next;
    logic [WINDOW_DEPTH-1:0] ring_valid_reg, ring_valid_next;
    logic [WPOS_W-1:0] wpos_reg, wpos_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic              div_start_reg, div_start_next;
    logic              result_valid_reg, result_valid_next;

    logic [31:0]        delta_reg, delta_next;
    logic [15:0]        elapsed_reg, elapsed_next;
    logic [DIV_N_W-1:0] rate_n_reg, rate_n_next;
    logic [DIV_D_W-1:0] rate_d_reg, rate_d_next;
    logic [DIV_N_W-1:0] div_n_reg, div_n_next;
    logic [DIV_D_W-1:0] div_d_reg, div_d_next;
    logic [31:0]        avg_reg, avg_next;
    pfm_out_t           result_reg, result_next;

    logic [15:0]       period_eff;
    logic [15:0]       ticks_inc;
    logic [32:0]       vol_add;
    logic [31:0]       ring_rdata;
    logic [31:0]       ring_old;
    logic [SUM_W-1:0]  sum_new;
    logic [FILL_W-1:0] fill_new;
    logic              ring_we;

    pfm_div_req_t div_req;
    pfm_div_rsp_t div_rsp;

    assign period_eff = (period == '0) ? 16'd1 : period;
    assign ticks_inc  = (ticks_reg == 16'hFFFF) ? ticks_reg : ticks_reg + 16'd1;
    assign vol_add    = {1'b0, volume_sum_reg} + {1'b0, sat32(div_rsp.quotient)};
    assign ring_old   = ring_valid_reg[wpos_reg] ? ring_rdata : 32'd0;
    assign sum_new    = sum_reg - SUM_W'(ring_old) + SUM_W'(latest_rate_reg);
    assign fill_new   = (fill_reg == FILL_W'(WINDOW_DEPTH)) ? fill_reg : fill_reg + 1'b1;
    assign ring_we    = (state_reg == S_PUSH);

    assign div_req.start    = div_start_reg;
    assign div_req.dividend = div_n_reg;
    assign div_req.divisor  = div_d_reg;

    pfm_div u_div (
        .clk (clk),
        .rst_n (rst_n),
        .req (div_req),
        .rsp (div_rsp)
    );

    pfm_ram #(
        .WIDTH (32),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ring_we),
        .waddr (wpos_reg),
        .wdata (latest_rate_reg),
        .raddr (wpos_reg),
        .rdata (ring_rdata)
    );

    assign cmd_ready    = (state_reg == S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        state_next        = state_reg;
        pulse_total_next  = pulse_total_reg;
        pulses_last_next  = pulses_last_reg;
        ticks_next        = ticks_reg;
        volume_sum_next   = volume_sum_reg;
        latest_rate_next  = latest_rate_reg;
        factor_next       = factor_reg;
        ring_valid_next   = ring_valid_reg;
        wpos_next         = wpos_reg;
        fill_next         = fill_reg;
        sum_next          = sum_reg;
        div_start_next    = 1'b0;
        result_valid_next = result_valid_reg && !result_ready;
        delta_next        = delta_reg;
        elapsed_next      = elapsed_reg;
        rate_n_next       = rate_n_reg;
        rate_d_next       = rate_d_reg;
        div_n_next        = div_n_reg;
        div_d_next        = div_d_reg;
        avg_next          = avg_reg;
        result_next       = result_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        FUNC_PULSE:
                        begin
                            pulse_total_next = pulse_total_reg + 32'd1;
                        end
                        FUNC_CLEAR:
                        begin
                            pulse_total_next = '0;
                            pulses_last_next = '0;
                            volume_sum_next  = '0;
                            latest_rate_next = '0;
                            ring_valid_next  = '0;
                            wpos_next        = '0;
                            fill_next        = '0;
                            sum_next         = '0;
                        end
                        FUNC_CALIB:
                        begin
                            if (pulse_total_reg != '0)
                            begin
                                div_n_next     = DIV_N_W'(pulse_total_reg) * DIV_N_W'(VOL_SCALE);
                                div_d_next     = DIV_D_W'(cmd.volume);
                                div_start_next = 1'b1;
                                state_next     = S_CAL;
                            end
                        end
                        FUNC_TICK:
                        begin
                            ticks_next = ticks_inc;
                            if (ticks_inc >= period_eff)
                            begin
                                elapsed_next     = ticks_inc;
                                delta_next       = pulse_total_reg - pulses_last_reg;
                                pulses_last_next = pulse_total_reg;
                                ticks_next       = '0;
                                state_next       = (factor_reg != '0) ? S_MUL : S_PUSH;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_MUL:
            begin
                div_n_next     = DIV_N_W'(delta_reg) * DIV_N_W'(VOL_SCALE);
                div_d_next     = DIV_D_W'(factor_reg);
                rate_n_next    = DIV_N_W'(delta_reg) * DIV_N_W'(RATE_SCALE);
                rate_d_next    = DIV_D_W'(factor_reg) * DIV_D_W'(elapsed_reg);
                div_start_next = 1'b1;
                state_next     = S_VOL;
            end
            S_VOL:
            begin
                if (div_rsp.done)
                begin
                    volume_sum_next = vol_add[32] ? 32'hFFFF_FFFF : vol_add[31:0];
                    div_n_next      = rate_n_reg;
                    div_d_next      = rate_d_reg;
                    div_start_next  = 1'b1;
                    state_next      = S_RATE;
                end
            end
            S_RATE:
            begin
                if (div_rsp.done)
                begin
                    latest_rate_next = sat32(div_rsp.quotient);
                    state_next       = S_PUSH;
                end
            end
            S_PUSH:
            begin
                ring_valid_next[wpos_reg] = 1'b1;
                wpos_next      = (wpos_reg == WPOS_W'(WINDOW_DEPTH - 1)) ? '0 : wpos_reg + 1'b1;
                fill_next      = fill_new;
                sum_next       = sum_new;
                div_n_next     = DIV_N_W'(sum_new);
                div_d_next     = DIV_D_W'(fill_new);
                div_start_next = 1'b1;
                state_next     = S_AVG;
            end
            S_AVG:
            begin
                if (div_rsp.done)
                begin
                    avg_next   = div_rsp.quotient[31:0];
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    result_next.rate_ul_per_s     = latest_rate_reg;
                    result_next.total_volume_ul   = volume_sum_reg;
                    result_next.avg_rate_ul_per_s = avg_reg;
                    result_next.factor_q8         = factor_reg;
                    result_valid_next             = 1'b1;
                    state_next                    = S_IDLE;
                end
            end
            S_CAL:
            begin
                if (div_rsp.done)
                begin
                    factor_next = sat24(div_rsp.quotient);
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            pulse_total_reg  <= '0;
            pulses_last_reg  <= '0;
            ticks_reg        <= '0;
            volume_sum_reg   <= '0;
            latest_rate_reg  <= '0;
            factor_reg       <= FACTOR_RESET;
            ring_valid_reg   <= '0;
            wpos_reg         <= '0;
            fill_reg         <= '0;
            sum_reg          <= '0;
            div_start_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            pulse_total_reg  <= pulse_total_next;
            pulses_last_reg  <= pulses_last_next;
            ticks_reg        <= ticks_next;
            volume_sum_reg   <= volume_sum_next;
            latest_rate_reg  <= latest_rate_next;
            factor_reg       <= factor_next;
            ring_valid_reg   <= ring_valid_next;
            wpos_reg         <= wpos_next;
            fill_reg         <= fill_next;
            sum_reg          <= sum_next;
            div_start_reg    <= div_start_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        delta_reg   <= delta_next;
        elapsed_reg <= elapsed_next;
        rate_n_reg  <= rate_n_next;
        rate_d_reg  <= rate_d_next;
        div_n_reg   <= div_n_next;
        div_d_reg   <= div_d_next;
        avg_reg     <= avg_next;
        result_reg  <= result_next;
    end

    `PFM_ASSERT(a_fill_bound, fill_reg <= FILL_W'(WINDOW_DEPTH), "ring fill out of range")
    `PFM_ASSERT(a_div_free, div_start_reg |-> !div_rsp.busy, "divider restarted while busy")
    `PFM_ASSERT_NEXT(a_push_fills, state_reg == S_PUSH, fill_reg != '0, "push left ring empty")

endmodule

`default_nettype wire

// ===== rtl/core/pulse_flow_meter_with_moving_average_core.sv =====
// channel   signals                              dir  payload
// item      item_valid / item_ready / item       in   pfm_in_t  (func, actual_volume_ul)
// result    result_valid / result_ready / result out  pfm_out_t (rate, total, avg, factor)
// config    cfg_write / cfg_index / cfg_data     in   update period at index 0
//
// Pulse, clear and non-final tick transfers retire straight from idle; a 4-deep queue takes
// items while the back end works. A calibrate makes one 64-step pass of the shared restoring
// divider, and a tick that ends a period makes three such passes, or one at factor 0.
// Reset zeroes counts, total, rate and ring (per-entry valid bits, no clearing pass),
// period 100, factor 512. item_ready drops only when the queue is full; a result
// waiting in the output register holds the back end only when the next one is ready.
`default_nettype none

module pulse_flow_meter_with_moving_average_core
    import pfm_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire pfm_in_t               item,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output pfm_out_t                   result,
    input  wire logic                  cfg_write,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // there is no initial-factor register: the factor resets to 512 and index 1 writes are ignored
    logic [15:0] period_reg, period_next;

    logic     cmd_valid;
    logic     cmd_ready;
    pfm_cmd_t cmd;

    always_comb
    begin
        period_next = period_reg;
        if (cfg_write && (cfg_index == REG_UPDATE_PERIOD))
        begin
            period_next = cfg_data[15:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg <= PERIOD_RESET;
        end
        else
        begin
            period_reg <= period_next;
        end
    end

    pfm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .cmd_valid  (cmd_valid),
        .cmd_ready  (cmd_ready),
        .cmd        (cmd)
    );

    pfm_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .period       (period_reg),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

// ===== tb/tb_pulse_flow_meter_with_moving_average_core.sv =====
`timescale 1ns / 100ps

module tb_pulse_flow_meter_with_moving_average_core;
    import pfm_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_INIT_FACTOR = 1'b1;
    localparam int WIN = WINDOW_DEPTH_DEF;
    localparam int WDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 1200;
    localparam int PHASE_ITEMS = 145;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic item_valid = 1'b0;
    logic item_ready;
    pfm_in_t item = '0;
    logic result_valid;
    logic result_ready = 1'b0;
    pfm_out_t result;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // flow model
    logic [31:0] pulse_count = '0;
    logic [31:0] pulse_mark = '0;
    logic [15:0] tick_count = '0;
    logic [31:0] vol_acc = '0;
    logic [31:0] rate_now = '0;
    logic [31:0] rate_hist [WIN] = '{default: '0};
    int hist_wr = 0;
    int hist_cnt = 0;
    logic [23:0] cal_factor = FACTOR_RESET;
    logic [15:0] period_ms = PERIOD_RESET;
    logic [23:0] init_factor_reg = FACTOR_RESET;

    pfm_out_t flow_expect [$];
    int mismatch_count = 0;
    int idle_cycles = 0;
    int hold_req = 0;
    int burst_left = 0;
    int sent_count = 0;
    bit gaps_on = 1'b1;

    pulse_flow_meter_with_moving_average_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [31:0] clamp32(input logic [63:0] v);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch %s: got 0x%08h expected 0x%08h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic predict_flow(input pfm_in_t it);
        logic [31:0] delta;
        logic [15:0] eff_period;
        logic [15:0] elapsed;
        logic [63:0] scaled;
        logic [63:0] q;
        logic [63:0] ring_sum;
        pfm_out_t r;
        if (it.func == FUNC_PULSE)
        begin
            pulse_count = pulse_count + 32'd1;
        end
        else if (it.func == FUNC_CLEAR)
        begin
            pulse_count = '0;
            pulse_mark = '0;
            vol_acc = '0;
            rate_now = '0;
            foreach (rate_hist[i])
                rate_hist[i] = '0;
            hist_wr = 0;
            hist_cnt = 0;
        end
        else if (it.func == FUNC_CALIB)
        begin
            if (it.actual_volume_ul != 0 && pulse_count != 0)
            begin
                q = 64'(pulse_count) * 64'(VOL_SCALE) / 64'(it.actual_volume_ul);
                cal_factor = (q > 64'hFF_FFFF) ? 24'hFF_FFFF : q[23:0];
            end
        end
        else
        begin
            if (tick_count != 16'hFFFF)
                tick_count = tick_count + 16'd1;
            eff_period = (period_ms == 0) ? 16'd1 : period_ms;
            if (tick_count >= eff_period)
            begin
                elapsed = tick_count;
                delta = pulse_count - pulse_mark;
                pulse_mark = pulse_count;
                tick_count = '0;
                if (cal_factor != 0)
                begin
                    scaled = 64'(delta) * 64'(VOL_SCALE);
                    vol_acc = clamp32(64'(vol_acc) + 64'(clamp32(scaled / 64'(cal_factor))));
                    rate_now = clamp32(scaled * 64'd1000 / (64'(cal_factor) * 64'(elapsed)));
                end
                rate_hist[hist_wr] = rate_now;
                hist_wr = (hist_wr == WIN - 1) ? 0 : hist_wr + 1;
                if (hist_cnt < WIN)
                    hist_cnt++;
                ring_sum = '0;
                for (int i = 0; i < hist_cnt; i++)
                    ring_sum += 64'(rate_hist[i]);
                r.rate_ul_per_s = rate_now;
                r.total_volume_ul = vol_acc;
                r.avg_rate_ul_per_s = clamp32(ring_sum / 64'(hist_cnt));
                r.factor_q8 = cal_factor;
                flow_expect.push_back(r);
            end
        end
    endtask

    task automatic send_item(input pfm_func_t f, input logic [23:0] vol);
        pfm_in_t it;
        int gap;
        it.func = f;
        it.actual_volume_ul = vol;
        if (gaps_on && burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 6);
            gap = $urandom_range(1, 8);
            @(negedge clk);
            item_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        item_valid <= 1'b1;
        item <= it;
        do @(posedge clk); while (!item_ready);
        predict_flow(it);
        sent_count++;
        if (burst_left > 0)
            burst_left--;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (flow_expect.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_UPDATE_PERIOD)
            period_ms = data[15:0];
        else
            init_factor_reg = data;
    endtask

    task automatic test_reset_defaults();
        send_item(FUNC_CALIB, 24'd0);
        send_item(FUNC_CALIB, 24'd1000);
        repeat (5) send_item(FUNC_PULSE, 24'($urandom));
        repeat (100) send_item(FUNC_TICK, 24'($urandom));
        send_item(FUNC_PULSE, 24'hFF_FFFF);
        send_item(FUNC_CLEAR, 24'($urandom));
        send_item(FUNC_PULSE, 24'd0);
        send_item(FUNC_CALIB, 24'd0);
        repeat (100) send_item(FUNC_TICK, 24'($urandom));
    endtask

    task automatic test_period_extremes();
        wait_idle();
        write_reg(REG_UPDATE_PERIOD, 24'd0);
        write_reg(REG_INIT_FACTOR, 24'd0);
        send_item(FUNC_PULSE, 24'($urandom));
        send_item(FUNC_TICK, 24'($urandom));
        send_item(FUNC_TICK, 24'($urandom));
        repeat (3) send_item(FUNC_PULSE, 24'($urandom));
        send_item(FUNC_TICK, 24'($urandom));
        wait_idle();
        write_reg(REG_UPDATE_PERIOD, 24'd1);
        send_item(FUNC_PULSE, 24'($urandom));
        send_item(FUNC_TICK, 24'($urandom));
        wait_idle();
        write_reg(REG_UPDATE_PERIOD, 24'd65535);
        write_reg(REG_INIT_FACTOR, 24'hFF_FFFF);
        for (int i = 0; i < 120; i++)
        begin
            if (i % 32 == 0)
                send_item(FUNC_PULSE, 24'($urandom));
            send_item(FUNC_TICK, 24'($urandom));
        end
        // ticks carried over into a shorter period
        wait_idle();
        write_reg(REG_UPDATE_PERIOD, 24'd3);
        send_item(FUNC_TICK, 24'($urandom));
    endtask

    task automatic test_calibrate();
        wait_idle();
        write_reg(REG_UPDATE_PERIOD, 24'd1);
        send_item(FUNC_CLEAR, 24'($urandom));
        send_item(FUNC_CALIB, 24'd5);
        repeat (66) send_item(FUNC_PULSE, 24'($urandom));
        send_item(FUNC_CALIB, 24'd1);
        send_item(FUNC_TICK, 24'($urandom));
        send_item(FUNC_CALIB, 24'hFF_FFFF);
        send_item(FUNC_PULSE, 24'($urandom));
        send_item(FUNC_TICK, 24'($urandom));
        send_item(FUNC_CLEAR, 24'($urandom));
        send_item(FUNC_PULSE, 24'($urandom));
        send_item(FUNC_TICK, 24'($urandom));
        // factor rounds to zero: rate held, ring still advances
        send_item(FUNC_CALIB, 24'hFF_FFFF);
        send_item(FUNC_PULSE, 24'($urandom));
        send_item(FUNC_PULSE, 24'($urandom));
        send_item(FUNC_TICK, 24'($urandom));
        send_item(FUNC_TICK, 24'($urandom));
        send_item(FUNC_CALIB, 24'd200);
        send_item(FUNC_PULSE, 24'($urandom));
        send_item(FUNC_TICK, 24'($urandom));
    endtask

    task automatic test_saturation();
        send_item(FUNC_CLEAR, 24'($urandom));
        send_item(FUNC_PULSE, 24'($urandom));
        send_item(FUNC_CALIB, 24'd256000);
        gaps_on = 1'b0;
        repeat (40) send_item(FUNC_PULSE, 24'($urandom));
        gaps_on = 1'b1;
        send_item(FUNC_TICK, 24'($urandom));
        send_item(FUNC_PULSE, 24'($urandom));
        send_item(FUNC_TICK, 24'($urandom));
        send_item(FUNC_TICK, 24'($urandom));
    endtask

    task automatic test_backpressure();
        wait_idle();
        write_reg(REG_UPDATE_PERIOD, 24'd1);
        send_item(FUNC_CALIB, 24'd1000);
        hold_req = 3000;
        repeat (40)
        begin
            repeat ($urandom_range(0, 3)) send_item(FUNC_PULSE, 24'($urandom));
            send_item(FUNC_TICK, 24'($urandom));
        end
    endtask

    task automatic test_random();
        int sel;
        int target;
        logic [23:0] vol;
        for (int ph = 0; ph < 5; ph++)
        begin
            wait_idle();
            case (ph)
                0: write_reg(REG_UPDATE_PERIOD, 24'd1);
                1: write_reg(REG_UPDATE_PERIOD, 24'd0);
                2: write_reg(REG_UPDATE_PERIOD, 24'($urandom_range(2, 6)));
                3: write_reg(REG_UPDATE_PERIOD, 24'($urandom_range(5, 12)));
                default: write_reg(REG_UPDATE_PERIOD, 24'd3);
            endcase
            write_reg(REG_INIT_FACTOR, 24'($urandom));
            target = sent_count + PHASE_ITEMS;
            while (sent_count < target)
            begin
                sel = $urandom_range(0, 19);
                if (sel == 0)
                begin
                    send_item(FUNC_CLEAR, 24'($urandom));
                end
                else if (sel <= 2)
                begin
                    sel = $urandom_range(0, 9);
                    if (sel == 0)
                        vol = 24'd0;
                    else if (sel < 6)
                        vol = 24'($urandom_range(1, 4096));
                    else
                        vol = 24'($urandom);
                    send_item(FUNC_CALIB, vol);
                end
                else if (sel == 3)
                begin
                    send_item(pfm_func_t'($urandom_range(0, 3)), 24'($urandom));
                end
                else
                begin
                    repeat ($urandom_range(0, 12)) send_item(FUNC_PULSE, 24'($urandom));
                    repeat ($urandom_range(1, 4)) send_item(FUNC_TICK, 24'($urandom));
                end
            end
        end
    endtask

    // receiver stall pattern
    initial
    begin
        int mode;
        int left;
        int hold_cnt;
        mode = 0;
        left = 0;
        wait (rst_n);
        forever
        begin
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(20, 200);
            end
            @(negedge clk);
            left--;
            if (hold_req != 0)
            begin
                hold_cnt = hold_req;
                hold_req = 0;
                result_ready <= 1'b0;
                repeat (hold_cnt) @(negedge clk);
            end
            else
            begin
                case (mode)
                    0: result_ready <= 1'b1;
                    1: result_ready <= 1'($urandom_range(0, 1));
                    2: result_ready <= ($urandom_range(0, 3) == 0);
                    default: result_ready <= (left % 3 == 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        pfm_out_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (flow_expect.size() == 0)
            begin
                report_mismatch("result with nothing pending", result.rate_ul_per_s, 32'd0);
            end
            else
            begin
                want = flow_expect.pop_front();
                if (result.rate_ul_per_s !== want.rate_ul_per_s)
                    report_mismatch("rate_ul_per_s", result.rate_ul_per_s, want.rate_ul_per_s);
                if (result.total_volume_ul !== want.total_volume_ul)
                    report_mismatch("total_volume_ul", result.total_volume_ul,
                                    want.total_volume_ul);
                if (result.avg_rate_ul_per_s !== want.avg_rate_ul_per_s)
                    report_mismatch("avg_rate_ul_per_s", result.avg_rate_ul_per_s,
                                    want.avg_rate_ul_per_s);
                if (result.factor_q8 !== want.factor_q8)
                    report_mismatch("factor_q8", 32'(result.factor_q8), 32'(want.factor_q8));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && item_ready) || (result_valid && result_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= WDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_period_extremes();
        test_calibrate();
        test_saturation();
        test_backpressure();
        test_random();
        wait_idle();
        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/pfm_pkg.sv
rtl/core/pfm_ram.sv
rtl/core/pfm_div.sv
rtl/core/pfm_front.sv
rtl/core/pfm_back.sv
rtl/core/pulse_flow_meter_with_moving_average_core.sv
tb/tb_pulse_flow_meter_with_moving_average_core.sv
